// File: sv/bcct_pkg.sv
`timescale 1ns / 1ps
// Shared types, sizes and codes for the box and circle collision table.
// Used by the input channel interface and every module of the block; depends on nothing.
package bcct_pkg;

  // Table sizes and the index/count widths that follow from them
  localparam int MAX_BOXES   = 64;
  localparam int MAX_CIRCLES = 64;
  localparam int BOX_AW      = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int BOX_CW      = $clog2(MAX_BOXES + 1);
  localparam int CIRC_AW     = (MAX_CIRCLES > 1) ? $clog2(MAX_CIRCLES) : 1;
  localparam int CIRC_CW     = $clog2(MAX_CIRCLES + 1);

  // Field and datapath widths
  localparam int KIND_W  = 2;
  localparam int COORD_W = 16;  // signed left/top
  localparam int SIZE_W  = 15;  // unsigned width/height
  localparam int EDGE_W  = 17;  // signed right/bottom and circle centre
  localparam int RAD_W   = 14;  // circle radius = height / 2
  localparam int DIFF_W  = 17;  // magnitude of centre-to-rectangle gap on one axis
  localparam int SQ_W    = 34;  // square of a gap, and sum of two squares

  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR      = 2'd0,
    KIND_ADD_BOX    = 2'd1,
    KIND_ADD_CIRCLE = 2'd2,
    KIND_QUERY      = 2'd3
  } kind_t;

  // Box as stored, and query rectangle: edges precomputed, nz = nonzero area
  typedef struct packed {
    logic signed [COORD_W-1:0] left;
    logic signed [COORD_W-1:0] top;
    logic signed [EDGE_W-1:0]  right;
    logic signed [EDGE_W-1:0]  bottom;
    logic                      nz;
  } rect_t;

  typedef struct packed {
    logic signed [EDGE_W-1:0] cx;
    logic signed [EDGE_W-1:0] cy;
    logic [RAD_W-1:0]         radius;
  } circle_entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BOX,
    ST_C_RD,
    ST_C_DIFF,
    ST_C_SQX,
    ST_C_SQY,
    ST_C_SQR,
    ST_C_CMP,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    UOP_IDLE,
    UOP_BOX,
    UOP_DIFF,
    UOP_SQX,
    UOP_SQY,
    UOP_SQR,
    UOP_CMP
  } unit_op_t;

  // Port controls of the two obstacle tables
  typedef struct packed {
    logic               box_we;
    logic               box_re;
    logic [BOX_AW-1:0]  box_addr;
    logic               circ_we;
    logic               circ_re;
    logic [CIRC_AW-1:0] circ_addr;
  } store_ctl_t;

endpackage

// File: sv/bcct_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the command input and the result output.
// Depends on bcct_pkg for the field widths.
interface bcct_in_if;
  import bcct_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [KIND_W-1:0]         kind;
  logic signed [COORD_W-1:0] rect_left;
  logic signed [COORD_W-1:0] rect_top;
  logic [SIZE_W-1:0]         rect_width;
  logic [SIZE_W-1:0]         rect_height;

  modport source (output valid, kind, rect_left, rect_top, rect_width, rect_height,
                  input ready);
  modport sink (input valid, kind, rect_left, rect_top, rect_width, rect_height,
                output ready);
endinterface

interface bcct_out_if;
  logic valid;
  logic ready;
  logic hit;
  logic table_full;

  modport source (output valid, hit, table_full, input ready);
  modport sink (input valid, hit, table_full, output ready);
endinterface

// File: sv/bcct_store.sv
`timescale 1ns / 1ps
// Box and circle obstacle tables: one read/write port each, registered read data.
// Depends on bcct_pkg.
module bcct_store (
  input  logic                    clk,
  input  bcct_pkg::store_ctl_t    ctl,
  input  bcct_pkg::rect_t         box_wdata,
  input  bcct_pkg::circle_entry_t circ_wdata,
  output bcct_pkg::rect_t         box_rdata,
  output bcct_pkg::circle_entry_t circ_rdata
);
  import bcct_pkg::*;

  rect_t         box_mem [MAX_BOXES];
  circle_entry_t circ_mem [MAX_CIRCLES];
  rect_t         box_rd_r;
  circle_entry_t circ_rd_r;

  always_ff @(posedge clk) begin
    if (ctl.box_we) begin
      box_mem[ctl.box_addr] <= box_wdata;
    end
    if (ctl.box_re) begin
      box_rd_r <= box_mem[ctl.box_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.circ_we) begin
      circ_mem[ctl.circ_addr] <= circ_wdata;
    end
    if (ctl.circ_re) begin
      circ_rd_r <= circ_mem[ctl.circ_addr];
    end
  end

  assign box_rdata  = box_rd_r;
  assign circ_rdata = circ_rd_r;

endmodule

// File: sv/bcct_unit.sv
`timescale 1ns / 1ps
// Shared test unit: box overlap compare, per-axis gap, one squarer and an accumulator.
// Depends on bcct_pkg; sequenced by the top level one op per cycle.
module bcct_unit (
  input  logic                    clk,
  input  bcct_pkg::unit_op_t      op,
  input  bcct_pkg::rect_t         box,
  input  bcct_pkg::circle_entry_t circ,
  input  bcct_pkg::rect_t         query,
  output logic                    match
);
  import bcct_pkg::*;

  logic [DIFF_W-1:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic [SQ_W-1:0]   prod_r, prod_nxt, acc_r, acc_nxt;
  logic [DIFF_W-1:0] mul_a;
  logic [SQ_W-1:0]   sq;
  logic              box_hit;

  // Distance from centre coordinate c to the interval [lo, hi], lo <= hi
  function automatic logic [DIFF_W-1:0] axis_gap(
    input logic signed [EDGE_W-1:0]  c,
    input logic signed [COORD_W-1:0] lo,
    input logic signed [EDGE_W-1:0]  hi
  );
    logic signed [EDGE_W:0] below;
    logic signed [EDGE_W:0] above;
    below = {{2{lo[COORD_W-1]}}, lo} - {c[EDGE_W-1], c};
    above = {c[EDGE_W-1], c} - {hi[EDGE_W-1], hi};
    if ($signed(c) < $signed(lo)) begin
      return below[DIFF_W-1:0];
    end else if ($signed(c) > $signed(hi)) begin
      return above[DIFF_W-1:0];
    end
    return '0;
  endfunction

  // Positive-area overlap: each left/top lies strictly before the other right/bottom
  assign box_hit = box.nz && query.nz &&
                   ($signed(box.left) < $signed(query.right)) &&
                   ($signed(query.left) < $signed(box.right)) &&
                   ($signed(box.top) < $signed(query.bottom)) &&
                   ($signed(query.top) < $signed(box.bottom));

  always_comb begin
    case (op)
      UOP_SQX: mul_a = dx_r;
      UOP_SQY: mul_a = dy_r;
      default: mul_a = DIFF_W'(circ.radius);
    endcase
  end

  assign sq = SQ_W'(mul_a) * SQ_W'(mul_a);

  always_comb begin
    dx_nxt   = dx_r;
    dy_nxt   = dy_r;
    prod_nxt = prod_r;
    acc_nxt  = acc_r;
    match    = 1'b0;
    case (op)
      UOP_BOX: begin
        match = box_hit;
      end
      UOP_DIFF: begin
        dx_nxt = axis_gap(circ.cx, query.left, query.right);
        dy_nxt = axis_gap(circ.cy, query.top, query.bottom);
      end
      UOP_SQX: begin
        prod_nxt = sq;
      end
      UOP_SQY: begin
        acc_nxt  = prod_r;
        prod_nxt = sq;
      end
      UOP_SQR: begin
        acc_nxt  = acc_r + prod_r;
        prod_nxt = sq;
      end
      UOP_CMP: begin
        // Strictly inside: squared distance below squared radius
        match = (acc_r < prod_r);
      end
      default: begin
        match = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    dx_r   <= dx_nxt;
    dy_r   <= dy_nxt;
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
  end

endmodule

// File: sv/box_circle_collision_table.sv
`timescale 1ns / 1ps
// Box and circle collision table, top level: command sequencer, table counts, result register.
// Depends on bcct_pkg, bcct_if, bcct_store and bcct_unit.
//
// Each input beat carries a kind and a rectangle. Clear empties both tables, add box
// stores the rectangle, add circle stores centre (left + width/2, top + height/2) and
// radius height/2, and query reports hit = 1 when the rectangle overlaps a stored box
// with positive area or its nearest point lies strictly inside a stored circle. An add
// into a full table (64 boxes or 64 circles) is dropped and reported with table_full = 1.
// Every input beat yields exactly one result beat. The block takes one command at a
// time and holds in_bus.ready low while it works. Clear and add go from accept
// straight to the emit state, which loads the result register. A query scans the stored
// boxes, then reads and tests each stored circle in turn: boxes stream out of the
// box table one per cycle, while every circle goes through the single squarer of the
// shared test unit three times (x gap, y gap, radius) before its compare. A finished
// result waits in the output register, and the next command is accepted meanwhile.
module box_circle_collision_table (
  input logic        clk,
  input logic        rst_n,
  bcct_in_if.sink    in_bus,
  bcct_out_if.source out_bus
);
  import bcct_pkg::*;

  state_t             state_r, state_nxt;
  logic [BOX_CW-1:0]  box_cnt_r, box_cnt_nxt;
  logic [CIRC_CW-1:0] circ_cnt_r, circ_cnt_nxt;
  logic [BOX_CW-1:0]  box_idx_r, box_idx_nxt;
  logic [CIRC_CW-1:0] circ_idx_r, circ_idx_nxt;
  logic               box_rv_r, box_rv_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               hit_r, hit_nxt;
  logic               full_r, full_nxt;
  logic               out_hit_r, out_hit_nxt;
  logic               out_full_r, out_full_nxt;
  rect_t              query_r, query_nxt;

  logic          in_ready;
  logic          in_take;
  kind_t         in_kind;
  rect_t         in_rect;
  circle_entry_t in_circ;
  store_ctl_t    ctl;
  unit_op_t      uop;
  logic          unit_match;
  rect_t         box_rdata;
  circle_entry_t circ_rdata;

  // Accept only between commands
  assign in_ready     = (state_r == ST_IDLE);
  assign in_take      = in_bus.valid && in_ready;
  assign in_bus.ready = in_ready;
  assign in_kind      = kind_t'(in_bus.kind);

  // Rectangle with precomputed right/bottom edges; nz marks positive area
  assign in_rect.left   = in_bus.rect_left;
  assign in_rect.top    = in_bus.rect_top;
  assign in_rect.right  = {in_bus.rect_left[COORD_W-1], in_bus.rect_left} +
                          {2'b00, in_bus.rect_width};
  assign in_rect.bottom = {in_bus.rect_top[COORD_W-1], in_bus.rect_top} +
                          {2'b00, in_bus.rect_height};
  assign in_rect.nz     = (|in_bus.rect_width) && (|in_bus.rect_height);

  // Circle from its bounding rectangle, halves truncated
  assign in_circ.cx     = {in_bus.rect_left[COORD_W-1], in_bus.rect_left} +
                          {3'b000, in_bus.rect_width[SIZE_W-1:1]};
  assign in_circ.cy     = {in_bus.rect_top[COORD_W-1], in_bus.rect_top} +
                          {3'b000, in_bus.rect_height[SIZE_W-1:1]};
  assign in_circ.radius = in_bus.rect_height[SIZE_W-1:1];

  bcct_store u_store (
    .clk        (clk),
    .ctl        (ctl),
    .box_wdata  (in_rect),
    .circ_wdata (in_circ),
    .box_rdata  (box_rdata),
    .circ_rdata (circ_rdata)
  );

  bcct_unit u_unit (
    .clk   (clk),
    .op    (uop),
    .box   (box_rdata),
    .circ  (circ_rdata),
    .query (query_r),
    .match (unit_match)
  );

  always_comb begin
    state_nxt     = state_r;
    box_cnt_nxt   = box_cnt_r;
    circ_cnt_nxt  = circ_cnt_r;
    box_idx_nxt   = box_idx_r;
    circ_idx_nxt  = circ_idx_r;
    box_rv_nxt    = box_rv_r;
    hit_nxt       = hit_r;
    full_nxt      = full_r;
    query_nxt     = query_r;
    out_hit_nxt   = out_hit_r;
    out_full_nxt  = out_full_r;
    out_valid_nxt = out_valid_r;
    ctl           = '0;
    uop           = UOP_IDLE;

    // Drop the result once the sink takes the beat
    if (out_valid_r && out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          hit_nxt   = 1'b0;
          full_nxt  = 1'b0;
          state_nxt = ST_EMIT;
          case (in_kind)
            KIND_CLEAR: begin
              box_cnt_nxt  = '0;
              circ_cnt_nxt = '0;
            end
            KIND_ADD_BOX: begin
              if (box_cnt_r != BOX_CW'(MAX_BOXES)) begin
                ctl.box_we   = 1'b1;
                ctl.box_addr = box_cnt_r[BOX_AW-1:0];
                box_cnt_nxt  = box_cnt_r + 1'b1;
              end else begin
                full_nxt = 1'b1;
              end
            end
            KIND_ADD_CIRCLE: begin
              if (circ_cnt_r != CIRC_CW'(MAX_CIRCLES)) begin
                ctl.circ_we   = 1'b1;
                ctl.circ_addr = circ_cnt_r[CIRC_AW-1:0];
                circ_cnt_nxt  = circ_cnt_r + 1'b1;
              end else begin
                full_nxt = 1'b1;
              end
            end
            KIND_QUERY: begin
              query_nxt    = in_rect;
              box_idx_nxt  = '0;
              circ_idx_nxt = '0;
              box_rv_nxt   = 1'b0;
              if (box_cnt_r != '0) begin
                state_nxt = ST_BOX;
              end else if (circ_cnt_r != '0) begin
                state_nxt = ST_C_RD;
              end
            end
            default: begin
              state_nxt = ST_EMIT;
            end
          endcase
        end
      end

      // Stream boxes: issue one read per cycle, test the entry read the cycle before
      ST_BOX: begin
        if (box_rv_r) begin
          uop = UOP_BOX;
          if (unit_match) begin
            hit_nxt = 1'b1;
          end
        end
        if (box_idx_r != box_cnt_r) begin
          ctl.box_re   = 1'b1;
          ctl.box_addr = box_idx_r[BOX_AW-1:0];
          box_idx_nxt  = box_idx_r + 1'b1;
          box_rv_nxt   = 1'b1;
        end else begin
          box_rv_nxt = 1'b0;
          if (!box_rv_r) begin
            state_nxt = (circ_cnt_r != '0) ? ST_C_RD : ST_EMIT;
          end
        end
      end

      // One circle at a time through the shared squarer
      ST_C_RD: begin
        ctl.circ_re   = 1'b1;
        ctl.circ_addr = circ_idx_r[CIRC_AW-1:0];
        circ_idx_nxt  = circ_idx_r + 1'b1;
        state_nxt     = ST_C_DIFF;
      end
      ST_C_DIFF: begin
        uop       = UOP_DIFF;
        state_nxt = ST_C_SQX;
      end
      ST_C_SQX: begin
        uop       = UOP_SQX;
        state_nxt = ST_C_SQY;
      end
      ST_C_SQY: begin
        uop       = UOP_SQY;
        state_nxt = ST_C_SQR;
      end
      ST_C_SQR: begin
        uop       = UOP_SQR;
        state_nxt = ST_C_CMP;
      end
      ST_C_CMP: begin
        uop = UOP_CMP;
        if (unit_match) begin
          hit_nxt = 1'b1;
        end
        state_nxt = (circ_idx_r == circ_cnt_r) ? ST_EMIT : ST_C_RD;
      end

      // Load the result register once it is free
      ST_EMIT: begin
        if (!out_valid_r || out_bus.ready) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = hit_r;
          out_full_nxt  = full_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      box_cnt_r   <= '0;
      circ_cnt_r  <= '0;
      box_idx_r   <= '0;
      circ_idx_r  <= '0;
      box_rv_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      box_cnt_r   <= box_cnt_nxt;
      circ_cnt_r  <= circ_cnt_nxt;
      box_idx_r   <= box_idx_nxt;
      circ_idx_r  <= circ_idx_nxt;
      box_rv_r    <= box_rv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hit_r      <= hit_nxt;
    full_r     <= full_nxt;
    query_r    <= query_nxt;
    out_hit_r  <= out_hit_nxt;
    out_full_r <= out_full_nxt;
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.hit        = out_hit_r;
  assign out_bus.table_full = out_full_r;

  a_box_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    box_cnt_r <= BOX_CW'(MAX_BOXES))
    else $error("box count above table size");

  a_circ_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    circ_cnt_r <= CIRC_CW'(MAX_CIRCLES))
    else $error("circle count above table size");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && in_kind == KIND_CLEAR) |=> (box_cnt_r == '0 && circ_cnt_r == '0))
    else $error("clear did not empty the tables");

  a_box_add: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && in_kind == KIND_ADD_BOX && box_cnt_r != BOX_CW'(MAX_BOXES))
      |=> (box_cnt_r == $past(box_cnt_r) + 1'b1))
    else $error("box add did not advance the count");

  a_flag_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_hit_r && out_full_r))
    else $error("hit and table_full raised on one result");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for box_circle_collision_table: drives commands and checks every result.
// Depends on bcct_pkg, the bcct_in_if/bcct_out_if channels and the block's RTL.
module tb_top;
  import bcct_pkg::*;

  localparam int CYCLE_LIMIT   = 2_500_000;  // watchdog budget for the whole run, sized for full-table queries
  localparam int RANDOM_ITEMS  = 1100;
  localparam int SETTLE_CYCLES = 20;         // idle wait after the final drain; queries always answer

  typedef struct {
    logic hit;
    logic table_full;
  } answer_t;

  typedef struct {
    int left;
    int top;
    int right;
    int bottom;
  } box_t;

  typedef struct {
    int cx;
    int cy;
    int radius;
  } circle_t;

  // Shadow copy of both obstacle tables plus the answers still owed by the block.
  class obstacle_tables;
    box_t    boxes[$];
    circle_t circles[$];
    answer_t pending_answers[$];
    int      mismatches;
    int      queries;
    int      hits;
    int      drops;
    int      checked;

    function new();
      mismatches = 0;
      queries    = 0;
      hits       = 0;
      drops      = 0;
      checked    = 0;
    endfunction

    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= 30) $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    // Positive-area overlap: larger left strictly below smaller right, same on y.
    function bit box_overlaps(box_t b, int ql, int qt, int qr, int qb);
      int lo_x;
      int hi_x;
      int lo_y;
      int hi_y;
      lo_x = (b.left > ql) ? b.left : ql;
      hi_x = (b.right < qr) ? b.right : qr;
      lo_y = (b.top > qt) ? b.top : qt;
      hi_y = (b.bottom < qb) ? b.bottom : qb;
      return (lo_x < hi_x) && (lo_y < hi_y);
    endfunction

    // Nearest point of the closed query rectangle strictly inside the radius.
    function bit circle_reaches(circle_t c, int ql, int qt, int qr, int qb);
      int     px;
      int     py;
      longint dx;
      longint dy;
      longint rr;
      px = (c.cx < ql) ? ql : ((c.cx > qr) ? qr : c.cx);
      py = (c.cy < qt) ? qt : ((c.cy > qb) ? qb : c.cy);
      dx = longint'(px) - longint'(c.cx);
      dy = longint'(py) - longint'(c.cy);
      rr = longint'(c.radius);
      return (dx * dx + dy * dy) < (rr * rr);
    endfunction

    function void apply_command(kind_t kind, logic signed [COORD_W-1:0] left,
                                logic signed [COORD_W-1:0] top,
                                logic [SIZE_W-1:0] width, logic [SIZE_W-1:0] height);
      answer_t ans;
      box_t    nb;
      circle_t nc;
      int      ql;
      int      qt;
      int      wi;
      int      hi;
      ql  = left;
      qt  = top;
      wi  = width;
      hi  = height;
      ans = '{hit: 1'b0, table_full: 1'b0};
      case (kind)
        KIND_CLEAR: begin
          boxes.delete();
          circles.delete();
        end
        KIND_ADD_BOX: begin
          if (boxes.size() < MAX_BOXES) begin
            nb = '{ql, qt, ql + wi, qt + hi};
            boxes.insert(boxes.size(), nb);
          end else begin
            ans.table_full = 1'b1;
          end
        end
        KIND_ADD_CIRCLE: begin
          if (circles.size() < MAX_CIRCLES) begin
            nc = '{ql + wi / 2, qt + hi / 2, hi / 2};
            circles.insert(circles.size(), nc);
          end else begin
            ans.table_full = 1'b1;
          end
        end
        KIND_QUERY: begin
          queries++;
          foreach (boxes[i])
            if (box_overlaps(boxes[i], ql, qt, ql + wi, qt + hi)) ans.hit = 1'b1;
          foreach (circles[i])
            if (circle_reaches(circles[i], ql, qt, ql + wi, qt + hi)) ans.hit = 1'b1;
        end
        default: ;
      endcase
      if (ans.hit) hits++;
      if (ans.table_full) drops++;
      pending_answers.insert(pending_answers.size(), ans);
    endfunction

    task check_answer(logic hit, logic table_full);
      answer_t want;
      if (pending_answers.size() == 0) begin
        report_mismatch("result beat arrived with no command outstanding");
      end else begin
        want = pending_answers.pop_front();
        checked++;
        if (hit !== want.hit)
          report_mismatch($sformatf("hit is %b, predicted %b (result %0d)",
                                    hit, want.hit, checked));
        if (table_full !== want.table_full)
          report_mismatch($sformatf("table_full is %b, predicted %b (result %0d)",
                                    table_full, want.table_full, checked));
      end
    endtask

    task close_out();
      if (pending_answers.size() != 0)
        report_mismatch($sformatf("%0d results never arrived", pending_answers.size()));
    endtask
  endclass

  logic clk;
  logic rst_n;
  int   cycle_count = 0;
  int   items_sent;
  bit   sender_idle;
  bit   receiver_idle;

  obstacle_tables tables = new();

  bcct_in_if  in_bus();
  bcct_out_if out_bus();

  box_circle_collision_table i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("[%0t] timeout after %0d cycles", $time, cycle_count);
    $display("tb_top failed");
    $finish;
  end

  // Result side: stall in random bursts while receiver_idle is set, else stay ready.
  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (receiver_idle && $urandom_range(0, 5) == 0) begin
        out_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
    end
  end

  // Check every accepted result beat against the oldest predicted answer.
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready)
      tables.check_answer(out_bus.hit, out_bus.table_full);
  end

  // Present one command and hold it until the block takes the beat. Valid stays high
  // afterwards so back-to-back commands go out without a bubble.
  task automatic send(kind_t kind, int left, int top, int width, int height);
    logic signed [COORD_W-1:0] lf;
    logic signed [COORD_W-1:0] tf;
    logic [SIZE_W-1:0]         wf;
    logic [SIZE_W-1:0]         hf;
    lf = COORD_W'(left);
    tf = COORD_W'(top);
    wf = SIZE_W'(width);
    hf = SIZE_W'(height);
    if (sender_idle && $urandom_range(0, 3) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_bus.valid       <= 1'b1;
    in_bus.kind        <= kind;
    in_bus.rect_left   <= lf;
    in_bus.rect_top    <= tf;
    in_bus.rect_width  <= wf;
    in_bus.rect_height <= hf;
    do @(posedge clk); while (!in_bus.ready);
    tables.apply_command(kind, lf, tf, wf, hf);
    items_sent++;
  endtask

  // Drop valid and hold off until every owed result has come back.
  task automatic drain();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (tables.pending_answers.size() != 0);
  endtask

  // Mostly a small neighborhood so boxes, circles and queries actually meet;
  // now and then anywhere in the 16-bit plane to toggle every bit.
  function automatic int pick_coord();
    if ($urandom_range(0, 9) < 8) return int'($urandom_range(0, 400)) - 200;
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic int pick_size();
    case ($urandom_range(0, 9))
      0:       return int'($urandom_range(0, 2));
      1:       return int'($urandom_range(0, 32767));
      default: return int'($urandom_range(1, 120));
    endcase
  endfunction

  task automatic send_random(kind_t kind);
    send(kind, pick_coord(), pick_coord(), pick_size(), pick_size());
  endtask

  // Small tables: usually start from clear, then a random mix of adds and queries,
  // with the odd stray clear thrown in.
  task automatic run_mixed_phase(int length);
    int roll;
    if ($urandom_range(0, 4) != 0) send_random(KIND_CLEAR);
    repeat (length) begin
      roll = $urandom_range(0, 99);
      if (roll < 30)      send_random(KIND_ADD_BOX);
      else if (roll < 60) send_random(KIND_ADD_CIRCLE);
      else if (roll < 97) send_random(KIND_QUERY);
      else                send_random(KIND_CLEAR);
    end
  endtask

  // Fill both tables past capacity so the overflow adds get dropped, then query
  // against the full tables (the slowest case of the block).
  task automatic run_fill_phase();
    int boxes_left;
    int circles_left;
    send_random(KIND_CLEAR);
    boxes_left   = MAX_BOXES + $urandom_range(1, 5);
    circles_left = MAX_CIRCLES + $urandom_range(1, 5);
    while (boxes_left > 0 || circles_left > 0) begin
      if ($urandom_range(0, 15) == 0) begin
        send_random(KIND_QUERY);
      end else if (circles_left == 0 || (boxes_left > 0 && $urandom_range(0, 1) == 0)) begin
        send_random(KIND_ADD_BOX);
        boxes_left--;
      end else begin
        send_random(KIND_ADD_CIRCLE);
        circles_left--;
      end
    end
    repeat (6) send_random(KIND_QUERY);
  endtask

  initial begin
    int phase_no;
    int directed_items;
    bit late;

    rst_n              <= 1'b0;
    in_bus.valid       <= 1'b0;
    in_bus.kind        <= KIND_CLEAR;
    in_bus.rect_left   <= '0;
    in_bus.rect_top    <= '0;
    in_bus.rect_width  <= '0;
    in_bus.rect_height <= '0;
    items_sent    = 0;
    sender_idle   = 1'b1;
    receiver_idle = 1'b1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty tables, edge contact, zero-size shapes, extremes of the plane.
    send(KIND_QUERY,      0,      0,      10,    10);     // nothing stored yet
    send(KIND_ADD_BOX,    0,      0,      10,    10);
    send(KIND_QUERY,      10,     0,      5,     5);      // shares an edge only
    send(KIND_QUERY,      9,      9,      1,     1);      // one-pixel overlap
    send(KIND_QUERY,      5,      5,      0,     0);      // zero-area query inside a box
    send(KIND_ADD_BOX,    -32768, -32768, 32767, 32767);
    send(KIND_QUERY,      -32768, -32768, 1,     1);
    send(KIND_QUERY,      32767,  32767,  32767, 32767);  // far corner of the plane
    send(KIND_ADD_BOX,    100,    100,    0,     50);     // zero-width box
    send(KIND_QUERY,      90,     90,     30,    30);
    send(KIND_CLEAR,      0,      0,      0,     0);
    send(KIND_QUERY,      9,      9,      1,     1);      // box gone after clear
    send(KIND_ADD_CIRCLE, 0,      0,      1,     1);      // radius truncates to zero
    send(KIND_QUERY,      0,      0,      5,     5);
    send(KIND_ADD_CIRCLE, 100,    100,    20,    20);     // centre (110,110), radius 10
    send(KIND_QUERY,      120,    110,    5,     5);      // exactly on the radius
    send(KIND_QUERY,      119,    110,    5,     5);      // one pixel inside
    send(KIND_QUERY,      105,    105,    0,     0);      // point query inside the circle
    send(KIND_ADD_CIRCLE, 32767,  32767,  32767, 32767);  // centre beyond 16 bits
    send(KIND_QUERY,      32767,  32767,  0,     0);
    send(KIND_QUERY,      32767,  32767,  32767, 32767);
    send(KIND_ADD_CIRCLE, -32768, -32768, 0,     32767);
    send(KIND_QUERY,      -32768, -32768, 0,     0);      // radius away on y only
    send(KIND_QUERY,      -32768, -16385, 32767, 0);      // crosses the centre
    send(KIND_ADD_BOX,    32767,  -32768, 32767, 0);      // zero-height box at the edge
    directed_items = items_sent;
    drain();

    // Random phases. Idling is chosen per phase and switched off for the last stretch.
    phase_no = 0;
    while (items_sent < directed_items + RANDOM_ITEMS) begin
      late          = (items_sent - directed_items) > (RANDOM_ITEMS * 85) / 100;
      sender_idle   = !late && $urandom_range(0, 3) != 0;
      receiver_idle = !late && $urandom_range(0, 3) != 0;
      if (phase_no == 2 || phase_no == 9) run_fill_phase();
      else run_mixed_phase($urandom_range(15, 40));
      if (phase_no == 1 || $urandom_range(0, 3) == 0) drain();
      phase_no++;
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    tables.close_out();

    $display("Covered %0d commands in %0d cycles: %0d queries with %0d hits,",
             items_sent, cycle_count, tables.queries, tables.hits);
    $display("%0d adds dropped on full tables, %0d result beats checked, %0d mismatches.",
             tables.drops, tables.checked, tables.mismatches);
    if (tables.mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
